@@ rtl/core/lifegs_pkg.sv @@
package lifegs_pkg;

   localparam int IDX_W  = 3;
   localparam int BITS_W = 8;

   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_STEP  = 1'b1;

   typedef struct packed {
      logic              func;
      logic [IDX_W-1:0]  row_index;
      logic [BITS_W-1:0] row_bits;
   } req_payload_type;

   typedef struct packed {
      logic [IDX_W-1:0]  row_index_res;
      logic [BITS_W-1:0] row_bits_res;
      logic              last_row;
   } rsp_payload_type;

   typedef struct packed {
      logic shift_en;
      logic load_en;
   } cell_ctrl_type;

endpackage

@@ rtl/core/life_automaton_generation_step.sv @@
// life grid step: a write request loads one row and gives no response
// a step request streams the grid once through a chain of row cells, one row per cycle
// while the output stage can take it; row 0 of the new generation is computed once the
// sequencer is busy and presented from the output stage register, and the rest follow
// one per cycle while rsp_ready holds; the next request is taken once the last row is
// registered in the output stage; synchronous reset clears every cell of the grid
module life_automaton_generation_step #(
   parameter int GRID_SIZE = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  lifegs_pkg::req_payload_type req_payload,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output lifegs_pkg::rsp_payload_type rsp_payload
);

   localparam int CNT_W = $clog2(GRID_SIZE);
   localparam int IDX_W = lifegs_pkg::IDX_W;
   localparam int BITS_W = lifegs_pkg::BITS_W;
   localparam logic [CNT_W-1:0] LAST_ROW = CNT_W'(GRID_SIZE - 1);

   // sequencer state
   logic             busy_ff,  busy_in;
   logic [CNT_W-1:0] cnt_ff,   cnt_in;
   // old row just above the one at the head of the chain
   logic [GRID_SIZE-1:0] prev_ff, prev_in;

   // output stage
   logic                        rsp_valid_ff, rsp_valid_in;
   lifegs_pkg::rsp_payload_type rsp_data_ff,  rsp_data_in;

   logic req_fire;
   logic step_fire;
   logic write_fire;
   logic advance;
   logic is_last;

   // cell row contents; cell 0 is the head of the chain
   logic [GRID_SIZE-1:0] cell_row [GRID_SIZE];
   logic [GRID_SIZE-1:0] below_row;
   logic [GRID_SIZE-1:0] new_row;
   logic [GRID_SIZE-1:0] load_row;

   // widening helpers for the fixed-width response fields
   logic [CNT_W+IDX_W-1:0]      idx_wide;
   logic [GRID_SIZE+BITS_W-1:0] bits_wide;
   logic [GRID_SIZE+BITS_W-1:0] load_wide;

   assign req_ready  = !busy_ff;
   assign req_fire   = req_valid && req_ready;
   assign step_fire  = req_fire && (req_payload.func == lifegs_pkg::FUNC_STEP);
   assign write_fire = req_fire && (req_payload.func == lifegs_pkg::FUNC_WRITE);

   // a row moves only when the output stage can take its result
   assign advance = busy_ff && (!rsp_valid_ff || rsp_ready);
   assign is_last = (cnt_ff == LAST_ROW);

   // row below the head: cell 1 holds it, except on the last row where
   // cell 1 already carries new row 0 and the outside of the grid is dead
   assign below_row = is_last ? '0 : cell_row[1];

   // incoming row bits, trimmed or zero-extended to the grid width
   assign load_wide = {{GRID_SIZE{1'b0}}, req_payload.row_bits};
   assign load_row  = load_wide[GRID_SIZE-1:0];

   lifegs_rule #(
      .WIDTH(GRID_SIZE)
   ) u_rule (
      .above   (prev_ff),
      .center  (cell_row[0]),
      .below   (below_row),
      .next_row(new_row)
   );

   // chain of row cells: each takes its successor's row on a shift, the tail
   // takes the freshly computed row, so after GRID_SIZE shifts the chain holds
   // the new generation in order
   for (genvar k = 0; k < GRID_SIZE; k++) begin : g_cell
      lifegs_pkg::cell_ctrl_type ctrl;
      logic [GRID_SIZE-1:0]      shift_src;

      if (k == GRID_SIZE - 1) begin : g_tail
         assign shift_src = new_row;
      end else begin : g_body
         assign shift_src = cell_row[k+1];
      end

      // rows past the index field's reach can never be written
      if (k < (1 << IDX_W)) begin : g_wr
         assign ctrl.load_en = write_fire && (req_payload.row_index == IDX_W'(k));
      end else begin : g_nowr
         assign ctrl.load_en = 1'b0;
      end
      assign ctrl.shift_en = advance;

      lifegs_cell #(
         .WIDTH(GRID_SIZE)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .load_data (load_row),
         .shift_data(shift_src),
         .row       (cell_row[k])
      );
   end

   // response fields keep only the low bits of index and row
   assign idx_wide  = {{IDX_W{1'b0}}, cnt_ff};
   assign bits_wide = {{BITS_W{1'b0}}, new_row};

   always_comb begin
      busy_in      = busy_ff;
      cnt_in       = cnt_ff;
      prev_in      = prev_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (step_fire) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         prev_in = '0;
      end

      if (advance) begin
         prev_in                   = cell_row[0];
         cnt_in                    = cnt_ff + 1'b1;
         rsp_valid_in              = 1'b1;
         rsp_data_in.row_index_res = idx_wide[IDX_W-1:0];
         rsp_data_in.row_bits_res  = bits_wide[BITS_W-1:0];
         rsp_data_in.last_row      = is_last;
         if (is_last) begin
            busy_in = 1'b0;
         end
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      prev_ff     <= prev_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

`ifndef SYNTHESIS
   // a step request starts the sweep from the top row
   a_step_start : assert property (@(posedge clock) disable iff (reset)
      step_fire |=> (busy_ff && (cnt_ff == '0)))
      else $error("step did not start at row 0");

   // the sweep ends right after the last row is produced
   a_step_end : assert property (@(posedge clock) disable iff (reset)
      (advance && is_last) |=> !busy_ff)
      else $error("sequencer still busy after last row");

   // every computed row lands in the output stage
   a_row_out : assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("computed row was not presented");

   // the final row is flagged only when it really is the last one
   a_last_flag : assert property (@(posedge clock) disable iff (reset)
      advance |=> (rsp_data_ff.last_row == $past(is_last)))
      else $error("last row flag mismatch");
`endif

endmodule

@@ rtl/core/lifegs_cell.sv @@
module lifegs_cell #(
   parameter int WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  lifegs_pkg::cell_ctrl_type ctrl,
   input  logic [WIDTH-1:0]         load_data,
   input  logic [WIDTH-1:0]         shift_data,
   output logic [WIDTH-1:0]         row
);

   logic [WIDTH-1:0] row_ff;
   logic [WIDTH-1:0] row_in;

   // shifting and loading never overlap: loads only happen while idle
   always_comb begin
      row_in = row_ff;
      if (ctrl.shift_en) begin
         row_in = shift_data;
      end else if (ctrl.load_en) begin
         row_in = load_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
      end else begin
         row_ff <= row_in;
      end
   end

   assign row = row_ff;

endmodule

@@ rtl/core/lifegs_rule.sv @@
module lifegs_rule #(
   parameter int WIDTH = 8
) (
   input  logic [WIDTH-1:0] above,
   input  logic [WIDTH-1:0] center,
   input  logic [WIDTH-1:0] below,
   output logic [WIDTH-1:0] next_row
);

   // one dead guard bit on each side, so edge columns see dead neighbors
   logic [WIDTH+1:0] pad_a;
   logic [WIDTH+1:0] pad_c;
   logic [WIDTH+1:0] pad_b;

   assign pad_a = {1'b0, above, 1'b0};
   assign pad_c = {1'b0, center, 1'b0};
   assign pad_b = {1'b0, below, 1'b0};

   always_comb begin
      logic [3:0] n;
      next_row = '0;
      for (int p = 0; p < WIDTH; p++) begin
         n = 4'(pad_a[p]) + 4'(pad_a[p+1]) + 4'(pad_a[p+2])
           + 4'(pad_c[p]) + 4'(pad_c[p+2])
           + 4'(pad_b[p]) + 4'(pad_b[p+1]) + 4'(pad_b[p+2]);
         next_row[p] = (n == 4'd3) || (center[p] && (n == 4'd2));
      end
   end

endmodule

@@ dv/tb_life_automaton_generation_step.sv @@
`timescale 1ns / 1ps

module tb_life_automaton_generation_step;

   localparam int GRID        = 8;
   localparam int HOLD_CYCLES = 150;
   localparam int QUIET_LIMIT = 2000;
   localparam int DRAIN_WAIT  = 20;

   // own copy of the grid; a step request queues the rows of the next generation
   class life_grid_checker #(int ROWS = 8);
      logic [lifegs_pkg::BITS_W-1:0] cells [ROWS];
      lifegs_pkg::rsp_payload_type   next_gen_rows [$];
      int                            errors;

      function new();
         foreach (cells[y]) cells[y] = '0;
         errors = 0;
      endfunction

      function int rows_pending();
         return next_gen_rows.size();
      endfunction

      function void note_request(lifegs_pkg::req_payload_type r);
         logic [lifegs_pkg::BITS_W-1:0] snap [ROWS];
         logic [lifegs_pkg::BITS_W-1:0] next_row;
         lifegs_pkg::rsp_payload_type   row;
         int                            count;
         int                            ny;
         int                            np;
         if (r.func == lifegs_pkg::FUNC_WRITE) begin
            if (r.row_index < ROWS) cells[r.row_index] = r.row_bits;
         end else begin
            snap = cells;
            for (int y = 0; y < ROWS; y++) begin
               next_row = '0;
               for (int p = 0; p < ROWS; p++) begin
                  count = 0;
                  for (int dy = -1; dy <= 1; dy++) begin
                     ny = y + dy;
                     if (ny >= 0 && ny < ROWS) begin
                        for (int dp = -1; dp <= 1; dp++) begin
                           np = p + dp;
                           if ((dy != 0 || dp != 0) && np >= 0 && np < ROWS)
                              count += snap[ny][np];
                        end
                     end
                  end
                  if (count == 3 || (snap[y][p] && count == 2)) next_row[p] = 1'b1;
               end
               cells[y] = next_row;
            end
            for (int y = 0; y < ROWS; y++) begin
               row.row_index_res = y[lifegs_pkg::IDX_W-1:0];
               row.row_bits_res  = cells[y];
               row.last_row      = (y == ROWS - 1);
               next_gen_rows.push_back(row);
            end
         end
      endfunction

      function void check_row(lifegs_pkg::rsp_payload_type got);
         lifegs_pkg::rsp_payload_type want;
         if (next_gen_rows.size() == 0) begin
            $display("%0t unexpected row: expected none actual %h", $time, got);
            errors++;
            return;
         end
         want = next_gen_rows.pop_front();
         if (got.row_index_res !== want.row_index_res) begin
            $display("%0t row_index_res mismatch: expected %h actual %h",
                     $time, want.row_index_res, got.row_index_res);
            errors++;
         end
         if (got.row_bits_res !== want.row_bits_res) begin
            $display("%0t row_bits_res mismatch: expected %h actual %h",
                     $time, want.row_bits_res, got.row_bits_res);
            errors++;
         end
         if (got.last_row !== want.last_row) begin
            $display("%0t last_row mismatch: expected %h actual %h",
                     $time, want.last_row, got.last_row);
            errors++;
         end
      endfunction
   endclass

   logic                        clock       = 1'b0;
   logic                        reset       = 1'b1;
   logic                        req_valid   = 1'b0;
   logic                        req_ready;
   lifegs_pkg::req_payload_type req_payload = '0;
   logic                        rsp_valid;
   logic                        rsp_ready   = 1'b0;
   lifegs_pkg::rsp_payload_type rsp_payload;

   // idle rates in percent, set by the stimulus
   int send_idle_pct = 0;
   int rsp_idle_pct  = 0;

   // long receiver hold-off: stimulus asks, receiver counts it out
   int hold_asked  = 0;
   int hold_served = 0;
   int hold_left   = 0;

   int quiet_cycles = 0;

   life_grid_checker #(GRID) grid_check;

   life_automaton_generation_step #(
      .GRID_SIZE(GRID)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // receiver: random stalls, or a counted hold-off when one is asked
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
      end else if (hold_served != hold_asked) begin
         hold_served++;
         hold_left = HOLD_CYCLES - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // monitor: check rows first, then note the request taken at the same edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) grid_check.check_row(rsp_payload);
         if (req_valid && req_ready) grid_check.note_request(req_payload);
         // watchdog on cycles with no handshake on either side
         if ((rsp_valid && rsp_ready) || (req_valid && req_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
               $display("%0t no handshake for %0d cycles", $time, quiet_cycles);
               $display("life_automaton_generation_step test failed");
               $finish;
            end
         end
      end
   end

   // offer one request and hold it until taken, then maybe idle a while
   task automatic send_request(input logic func,
                               input logic [lifegs_pkg::IDX_W-1:0] idx,
                               input logic [lifegs_pkg::BITS_W-1:0] bits);
      lifegs_pkg::req_payload_type p;
      p.func      = func;
      p.row_index = idx;
      p.row_bits  = bits;
      req_valid   <= 1'b1;
      req_payload <= p;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      // gap after acceptance; valid drops only here, never re-raised in this step
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
   endtask

   task automatic write_row(input int idx, input logic [lifegs_pkg::BITS_W-1:0] bits);
      send_request(lifegs_pkg::FUNC_WRITE, idx[lifegs_pkg::IDX_W-1:0], bits);
   endtask

   // step request with junk in the ignored fields
   task automatic step_grid();
      send_request(lifegs_pkg::FUNC_STEP, lifegs_pkg::IDX_W'($urandom),
                   lifegs_pkg::BITS_W'($urandom));
   endtask

   // sender stops offering until every queued row has come back
   task automatic wait_rows_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (grid_check.rows_pending() != 0) @(posedge clock);
   endtask

   // row of varied density: plain, sparse, dense, or an extreme
   function automatic logic [lifegs_pkg::BITS_W-1:0] random_row();
      case ($urandom_range(3))
         0: return lifegs_pkg::BITS_W'($urandom);
         1: return lifegs_pkg::BITS_W'($urandom & $urandom);
         2: return lifegs_pkg::BITS_W'($urandom | $urandom);
         default: return $urandom_range(1) ? '1 : '0;
      endcase
   endfunction

   // mostly a few row loads then a step; sometimes a bare step or a full reload
   task automatic run_generations(input int n_items);
      int sent;
      int loads;
      sent = 0;
      while (sent < n_items) begin
         case ($urandom_range(9))
            0:       loads = 0;
            1, 2:    loads = GRID;
            default: loads = $urandom_range(1, 4);
         endcase
         if (loads == GRID) begin
            for (int y = 0; y < GRID; y++) write_row(y, random_row());
         end else begin
            repeat (loads) write_row($urandom_range(GRID - 1), random_row());
         end
         step_grid();
         sent += loads + 1;
      end
   endtask

   initial begin
      grid_check = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // phase 1: sender idles a little, receiver a lot
      send_idle_pct = 21;
      rsp_idle_pct  = 64;

      // step on the cleared grid
      step_grid();
      // every cell alive, then two generations
      for (int y = 0; y < GRID; y++) write_row(y, '1);
      step_grid();
      step_grid();
      // corner cells, a blinker in the middle, empty rows elsewhere
      write_row(0, 8'h81);
      write_row(GRID - 1, 8'h81);
      write_row(3, 8'h38);
      write_row(1, '0);
      write_row(2, '0);
      write_row(4, '0);
      write_row(5, '0);
      write_row(6, '0);
      // steps with the ignored fields at both extremes
      send_request(lifegs_pkg::FUNC_STEP, '1, '1);
      send_request(lifegs_pkg::FUNC_STEP, '0, '0);

      run_generations(28);
      wait_rows_drained();

      // phase 2: roles swapped
      send_idle_pct = 64;
      rsp_idle_pct  = 21;
      run_generations(28);
      wait_rows_drained();

      // phase 3: no idling; first a long receiver hold while steps keep coming
      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      hold_asked++;
      repeat (4) step_grid();
      run_generations(22);

      // end of stimulus: drain, then let the pipeline settle
      wait_rows_drained();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (grid_check.errors == 0 && grid_check.rows_pending() == 0) begin
         $display("life_automaton_generation_step test passed");
      end else begin
         $display("life_automaton_generation_step test failed");
      end
      $finish;
   end

endmodule

@@ life_automaton_generation_step.f @@
rtl/core/lifegs_pkg.sv
rtl/core/lifegs_cell.sv
rtl/core/lifegs_rule.sv
rtl/core/life_automaton_generation_step.sv
dv/tb_life_automaton_generation_step.sv
